FILE: sv/hsr2_pkg.sv
// Shared types and codes for the Hessenberg symmetric rank-2k update block.
// No dependencies; the controller, datapath and top import this package.
package hsr2_pkg;

   localparam int DEF_MAX_ORDER = 8;
   localparam int IDX_W = 3;
   localparam int VAL_W = 32;
   localparam int ORD_W = 4;
   localparam int SUM_W = 68;   // sum of up to sixteen 64-bit products
   localparam int ACC_W = 88;   // alpha*R plus beta*S before the final shift
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] MODE_LOAD_R = 2'd0;
   localparam logic [1:0] MODE_LOAD_H = 2'd1;
   localparam logic [1:0] MODE_LOAD_X = 2'd2;
   localparam logic [1:0] MODE_START  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER     = 3'd4;

   typedef struct packed {
      logic [1:0]              mode;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [VAL_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] alpha_scale;
      logic signed [VAL_W-1:0] beta_scale;
      logic                    use_upper;
      logic                    transpose_form;
      logic [ORD_W-1:0]        order;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic             issue;   // read one H/X term pair
      logic             first;   // first term of an element: read R, clear sum
      logic             second;  // second product of the current l
      logic [IDX_W-1:0] l;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic             mlo;
      logic             mhi;
      logic             sum;
      logic             fin;
      logic             last;
   } cmd_type;

   // datapath and top to controller
   typedef struct packed {
      logic start;
      logic out_free;
   } status_type;

endpackage

FILE: sv/hsr2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsr2_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/hsr2_ctrl.sv
// Sequencer for the rank-2k update: walks the triangle and the term index.
// Depends on hsr2_pkg.
module hsr2_ctrl #(
   parameter int MAX_ORDER = hsr2_pkg::DEF_MAX_ORDER
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hsr2_pkg::cfg_type    cfg,
   input  hsr2_pkg::status_type stat,
   output hsr2_pkg::cmd_type    cmd,
   output logic                 busy
);
   import hsr2_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MLO   = 3'd3;
   localparam logic [2:0] ST_MHI   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [ORD_W-1:0] MAX_N = ORD_W'(MAX_ORDER);

   logic [2:0]       state_ff, state_in;
   logic [4:0]       term_ff, term_in;
   logic             drain_ff, drain_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;

   logic [ORD_W-1:0] n_eff;
   logic [IDX_W-1:0] n_last, row_hi;
   logic [4:0]       term_end;
   logic             last_elem;

   always_comb begin
      n_eff    = (cfg.order > MAX_N) ? MAX_N : cfg.order;
      n_last   = IDX_W'(n_eff - 4'd1);
      term_end = (cfg.beta_scale == '0) ? 5'd0 : 5'({n_eff, 1'b0} - 5'd1);
      row_hi   = cfg.use_upper ? j_ff : n_last;
      last_elem = (j_ff == n_last) && (i_ff == row_hi);
   end

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      drain_in = drain_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.start && n_eff != '0) begin
               state_in = ST_ISSUE;
               term_in  = '0;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_ISSUE: begin
            term_in = term_ff + 5'd1;
            if (term_ff == term_end) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_MLO;
            end
         end
         ST_MLO: state_in = ST_MHI;
         ST_MHI: state_in = ST_SUM;
         ST_SUM: state_in = ST_FIN;
         ST_FIN: begin
            if (stat.out_free) begin
               term_in = '0;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (i_ff == row_hi) begin
                     j_in = j_ff + 3'd1;
                     i_in = cfg.use_upper ? '0 : IDX_W'(j_ff + 3'd1);
                  end else begin
                     i_in = i_ff + 3'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
         drain_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         drain_ff <= drain_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      cmd.issue  = (state_ff == ST_ISSUE);
      cmd.first  = (state_ff == ST_ISSUE) && (term_ff == '0);
      cmd.second = term_ff[0];
      cmd.l      = term_ff[3:1];
      cmd.i      = i_ff;
      cmd.j      = j_ff;
      cmd.mlo    = (state_ff == ST_MLO);
      cmd.mhi    = (state_ff == ST_MHI);
      cmd.sum    = (state_ff == ST_SUM);
      cmd.fin    = (state_ff == ST_FIN) && stat.out_free;
      cmd.last   = last_elem;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

FILE: sv/hsr2_datapath.sv
// Stores, multiply-accumulate pipeline, scaling, saturation and result register.
// Depends on hsr2_pkg and hsr2_ram.
module hsr2_datapath #(
   parameter int MAX_ORDER = hsr2_pkg::DEF_MAX_ORDER
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hsr2_pkg::cfg_type         cfg,
   input  logic                      ld_en,
   input  hsr2_pkg::req_payload_type req_payload,
   input  hsr2_pkg::cmd_type         cmd,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output hsr2_pkg::rsp_payload_type rsp_payload,
   output logic                      out_free
);
   import hsr2_pkg::*;

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
      return AW'(int'(r) * MAX_ORDER + int'(c));
   endfunction

   // term operand selection
   logic [IDX_W-1:0] ha, hb, xa, xb;
   logic             hzero, x_direct, ld_in_range;
   logic [AW-1:0]    h_raddr, x_raddr, r_waddr;
   logic [VAL_W-1:0] r_q, h_q, x_q, r_wdata;
   logic             r_we, h_we, x_we;

   always_comb begin
      if (!cmd.second) begin
         ha = cfg.transpose_form ? cmd.l : cmd.i;
         hb = cfg.transpose_form ? cmd.i : cmd.l;
         xa = cmd.l;
         xb = cmd.j;
      end else begin
         ha = cfg.transpose_form ? cmd.l : cmd.j;
         hb = cfg.transpose_form ? cmd.j : cmd.l;
         xa = cmd.i;
         xb = cmd.l;
      end
      hzero    = ({1'b0, ha} > ({1'b0, hb} + 4'd1)) || (cfg.beta_scale == '0);
      x_direct = cfg.use_upper ? (xa <= xb) : (xa >= xb);
      h_raddr  = addr_of(ha, hb);
      x_raddr  = x_direct ? addr_of(xa, xb) : addr_of(xb, xa);
      ld_in_range = (int'(req_payload.row_index) < MAX_ORDER)
                 && (int'(req_payload.col_index) < MAX_ORDER);
   end

   // pipeline registers
   logic                      v1_ff, v2_ff, rv1_ff, z1_ff;
   logic signed [63:0]        prod_ff, ar_ff;
   logic signed [SUM_W-1:0]   s_ff;
   logic signed [58:0]        plo_ff;
   logic signed [57:0]        phi_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-17:0]  acc_sh;
   logic signed [VAL_W-1:0]   res;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff;

   always_comb begin
      acc_sh = acc_ff[ACC_W-1:16];
      if (acc_sh[ACC_W-17:VAL_W-1] == '0 || acc_sh[ACC_W-17:VAL_W-1] == '1) begin
         res = acc_sh[VAL_W-1:0];
      end else begin
         res = acc_sh[ACC_W-17] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   assign r_we    = (ld_en && ld_in_range && req_payload.mode == MODE_LOAD_R) || cmd.fin;
   assign r_waddr = cmd.fin ? addr_of(cmd.i, cmd.j)
                            : addr_of(req_payload.row_index, req_payload.col_index);
   assign r_wdata = cmd.fin ? res : req_payload.value;
   assign h_we    = ld_en && ld_in_range && req_payload.mode == MODE_LOAD_H;
   assign x_we    = ld_en && ld_in_range && req_payload.mode == MODE_LOAD_X;

   hsr2_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_r_ram (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_addr(addr_of(cmd.i, cmd.j)), .rd_data(r_q)
   );
   hsr2_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_h_ram (
      .clock(clock), .wr_en(h_we),
      .wr_addr(addr_of(req_payload.row_index, req_payload.col_index)),
      .wr_data(req_payload.value), .rd_addr(h_raddr), .rd_data(h_q)
   );
   hsr2_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_x_ram (
      .clock(clock), .wr_en(x_we),
      .wr_addr(addr_of(req_payload.row_index, req_payload.col_index)),
      .wr_data(req_payload.value), .rd_addr(x_raddr), .rd_data(x_q)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.fin ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rv1_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         rv1_ff       <= cmd.first;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z1_ff <= hzero;
      // mask rather than multiply: masked entries may never have been loaded
      prod_ff <= z1_ff ? 64'sd0 : 64'($signed(h_q) * $signed(x_q));
      if (cmd.first) begin
         s_ff <= '0;
      end else if (v2_ff) begin
         s_ff <= s_ff + SUM_W'(prod_ff);
      end
      if (rv1_ff) begin
         ar_ff <= 64'(cfg.alpha_scale * $signed(r_q));
      end
      if (cmd.mlo) begin
         plo_ff <= 59'($signed({1'b0, s_ff[41:16]}) * cfg.beta_scale);
      end
      if (cmd.mhi) begin
         phi_ff <= 58'($signed(s_ff[SUM_W-1:42]) * cfg.beta_scale);
      end
      if (cmd.sum) begin
         acc_ff <= ACC_W'(ar_ff) + (ACC_W'(phi_ff) <<< 26) + ACC_W'(plo_ff);
      end
      if (cmd.fin) begin
         rsp_ff.out_row   <= cmd.i;
         rsp_ff.out_col   <= cmd.j;
         rsp_ff.out_value <= res;
         rsp_ff.last      <= cmd.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

FILE: sv/hessenberg_symmetric_rank2_update.sv
// Top level of the Hessenberg symmetric rank-2k update block: CSRs and glue.
// Depends on hsr2_pkg, hsr2_ctrl, hsr2_datapath (and hsr2_ram below it).
//
//  port group | dir | handshake          | carries
//  req_*      | in  | req_valid/req_stall | mode, row_index, col_index, value
//  rsp_*      | out | rsp_valid/rsp_stall | out_row, out_col, out_value, last
//  csr_*      | in  | csr_wr_en           | csr_index, csr_wr_data
//
// Load transfers may arrive back to back while no update is running.
// A start transfer emits n*(n+1)/2 results; each element is read through the
// single read port of the H and X stores, one product per cycle (a single
// product when beta is zero), then drain, two beta partial products, sum, write.
// req_stall is high from the start transfer until the last element is written.
// Reset is synchronous; the stores are not cleared and need no sweep.
module hessenberg_symmetric_rank2_update #(
   parameter int MAX_ORDER = hsr2_pkg::DEF_MAX_ORDER
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  hsr2_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output hsr2_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [hsr2_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsr2_pkg::VAL_W-1:0]        csr_wr_data
);
   import hsr2_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type stat;
   logic       busy, req_xfer, ld_en, out_free;

   // Configuration registers; writes to unknown indexes drop.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ALPHA:     cfg_in.alpha_scale    = csr_wr_data;
            CSR_BETA:      cfg_in.beta_scale     = csr_wr_data;
            CSR_UPPER:     cfg_in.use_upper      = csr_wr_data[0];
            CSR_TRANSPOSE: cfg_in.transpose_form = csr_wr_data[0];
            CSR_ORDER:     cfg_in.order          = csr_wr_data[ORD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_scale    <= 32'sd65536;
         cfg_ff.beta_scale     <= 32'sd65536;
         cfg_ff.use_upper      <= 1'b1;
         cfg_ff.transpose_form <= 1'b0;
         cfg_ff.order          <= 4'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold the input off for the whole update.
   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign ld_en     = req_xfer && (req_payload.mode != MODE_START);

   always_comb begin
      stat.start    = req_xfer && (req_payload.mode == MODE_START);
      stat.out_free = out_free;
   end

   hsr2_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .stat(stat), .cmd(cmd), .busy(busy)
   );

   hsr2_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .ld_en(ld_en),
      .req_payload(req_payload), .cmd(cmd), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_payload(rsp_payload), .out_free(out_free)
   );

`ifndef SYNTH
   // never overwrite a result that is still waiting
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   // term reads only happen inside an update
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> req_stall)
      else $error("term read while idle");

   // a start with nonzero order locks the input
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (stat.start && cfg_ff.order != '0) |=> req_stall)
      else $error("start did not begin an update");
`endif
endmodule
